[design/assert_macros.svh]
// Assertion macros for the top level, which checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising aclk edge outside reset.
`define URLHE_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("urlhe assertion failed");

// Check that a condition never holds on a rising aclk edge outside reset.
`define URLHE_ASSERT_NEVER(label, cond) \
    `URLHE_ASSERT(label, !(cond))

`endif

[design/urlhe_pkg.sv]
// Shared types, character constants and lookup functions of the URL unescape unit.
package urlhe_pkg;

    // Characters the decoder and the escaper look for
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LG    = 8'h67;
    localparam logic [7:0] CH_LL    = 8'h6c;
    localparam logic [7:0] CH_LO    = 8'h6f;
    localparam logic [7:0] CH_LQ    = 8'h71;
    localparam logic [7:0] CH_LT_T  = 8'h74;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] HEX_CASE_MASK = 8'hdf;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

    // Output pieces per request never exceed seven
    localparam int unsigned IDX_W = 3;

    // Entity that replaces a decoded byte
    typedef enum logic [2:0] {
        ENT_NONE = 3'd0,
        ENT_LT   = 3'd1,
        ENT_GT   = 3'd2,
        ENT_QUOT = 3'd3,
        ENT_APOS = 3'd4
    } ent_kind_t;

    // One classified request handed from front to back
    typedef struct packed {
        logic       pct;      // emit a literal '%' first
        logic       has_byte; // a decoded byte follows
        ent_kind_t  kind;     // how the decoded byte is expanded
        logic [7:0] data;     // the decoded byte
        logic       last;     // request closes the string
    } job_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Non-validating hex digit value, modulo 256
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_UA) begin
            v = (c & HEX_CASE_MASK) - CH_UA + HEX_ALPHA_BASE;
        end else begin
            v = c - CH_0;
        end
        return v;
    endfunction

    // Number of output bytes a decoded byte expands to
    function automatic logic [IDX_W-1:0] ent_len(input ent_kind_t kind);
        logic [IDX_W-1:0] n;
        case (kind)
            ENT_LT:   n = 3'd4;
            ENT_GT:   n = 3'd4;
            ENT_QUOT: n = 3'd6;
            ENT_APOS: n = 3'd5;
            default:  n = 3'd1;
        endcase
        return n;
    endfunction

    // Byte at a given position of the expansion
    function automatic logic [7:0] ent_char(input ent_kind_t kind, input logic [7:0] data,
                                            input logic [IDX_W-1:0] pos);
        logic [7:0] c;
        c = data;
        case (kind)
            ENT_LT: begin
                case (pos)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = CH_LL;
                    3'd2:    c = CH_LT_T;
                    default: c = CH_SEMI;
                endcase
            end
            ENT_GT: begin
                case (pos)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = CH_LG;
                    3'd2:    c = CH_LT_T;
                    default: c = CH_SEMI;
                endcase
            end
            ENT_QUOT: begin
                case (pos)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = CH_LQ;
                    3'd2:    c = CH_LU;
                    3'd3:    c = CH_LO;
                    3'd4:    c = CH_LT_T;
                    default: c = CH_SEMI;
                endcase
            end
            ENT_APOS: begin
                case (pos)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = CH_HASH;
                    3'd2:    c = CH_3;
                    3'd3:    c = CH_9;
                    default: c = CH_SEMI;
                endcase
            end
            default: c = data;
        endcase
        return c;
    endfunction

endpackage

[design/urlhe_front.sv]
// Front end: accepts raw bytes, tracks escapes and string end, classifies each request.
module urlhe_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_byte,
    input  logic                  s_in_last,
    output logic                  push,
    output urlhe_pkg::job_t       push_job,
    input  urlhe_pkg::fifo_stat_t fifo_stat
);
    import urlhe_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    logic       enable_reg;
    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       ended_reg, ended_next;

    logic       accept;
    logic [7:0] plain_byte;
    logic [7:0] hi_val, lo_val, decoded;
    logic       cand_pct, cand_has;
    logic [7:0] cand_byte;
    logic       has_byte;
    ent_kind_t  kind;

    // Hold off the source while the queue has no room
    assign s_ready = !fifo_stat.full;
    assign accept  = s_valid && s_ready;

    // Map plain bytes and build the escaped value
    assign plain_byte = (s_in_byte == CH_PLUS) ? CH_SPACE : s_in_byte;
    assign hi_val     = hex_value(held_reg);
    assign lo_val     = hex_value(s_in_byte);
    assign decoded    = {hi_val[3:0], 4'b0000} + lo_val;

    // Classify the request and advance the escape state
    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        ended_next = ended_reg;
        cand_pct   = 1'b0;
        cand_has   = 1'b0;
        cand_byte  = plain_byte;
        if (!ended_reg) begin
            case (phase_reg)
                PH_PCT: begin
                    if (s_in_last) begin
                        cand_pct = 1'b1;
                        cand_has = 1'b1;
                    end else begin
                        held_next  = s_in_byte;
                        phase_next = PH_DIGIT;
                    end
                end
                PH_DIGIT: begin
                    cand_has   = 1'b1;
                    cand_byte  = decoded;
                    phase_next = PH_IDLE;
                end
                default: begin
                    if (s_in_byte == CH_PCT) begin
                        if (s_in_last) begin
                            cand_pct = 1'b1;
                        end else begin
                            phase_next = PH_PCT;
                        end
                    end else begin
                        cand_has = 1'b1;
                    end
                end
            endcase
        end
        // A zero byte ends the string and is dropped
        has_byte = cand_has;
        if (cand_has && (cand_byte == 8'h00)) begin
            has_byte   = 1'b0;
            ended_next = 1'b1;
        end
        // Return to the start state after the final byte
        if (s_in_last) begin
            phase_next = PH_IDLE;
            held_next  = 8'h00;
            ended_next = 1'b0;
        end
    end

    // Pick the entity for the decoded byte
    always_comb begin
        kind = ENT_NONE;
        if (enable_reg) begin
            case (cand_byte)
                CH_LT:   kind = ENT_LT;
                CH_GT:   kind = ENT_GT;
                CH_QUOT: kind = ENT_QUOT;
                CH_APOS: kind = ENT_APOS;
                default: kind = ENT_NONE;
            endcase
        end
    end

    // Queue a request only when it yields output
    assign push              = accept && (cand_pct || has_byte || s_in_last);
    assign push_job.pct      = cand_pct;
    assign push_job.has_byte = has_byte;
    assign push_job.kind     = kind;
    assign push_job.data     = cand_byte;
    assign push_job.last     = s_in_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
            phase_reg  <= PH_IDLE;
            held_reg   <= 8'h00;
            ended_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                ended_reg <= ended_next;
            end
        end
    end

endmodule

[design/urlhe_fifo.sv]
// Request queue between the front and back ends.
module urlhe_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  urlhe_pkg::job_t       push_job,
    input  logic                  pop,
    output urlhe_pkg::job_t       head_job,
    output urlhe_pkg::fifo_stat_t fifo_stat
);
    import urlhe_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign fifo_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign fifo_stat.empty = (count_reg == '0);
    assign head_job        = entry_reg[rd_ptr_reg];

    // Store the incoming request
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[design/urlhe_back.sv]
// Back end: expands each queued request into output bytes, one per cycle while the receiver accepts them.
module urlhe_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  urlhe_pkg::job_t       head_job,
    input  urlhe_pkg::fifo_stat_t fifo_stat,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_out_valid_byte,
    output logic                  m_out_last
);
    import urlhe_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic             m_valid_reg;
    logic [7:0]       m_byte_reg;
    logic             m_vbyte_reg;
    logic             m_last_reg;

    logic             out_free, take, final_piece;
    logic [IDX_W-1:0] seq_len, pos;
    logic [7:0]       piece_byte;
    logic             piece_vbyte;

    // Move a piece whenever the output register is free or draining
    assign out_free = !m_valid_reg || m_ready;
    assign take     = out_free && !fifo_stat.empty;

    // Length of the current request's output sequence
    always_comb begin
        seq_len = {{(IDX_W-1){1'b0}}, head_job.pct}
                + (head_job.has_byte ? ent_len(head_job.kind) : '0);
        if (!head_job.pct && !head_job.has_byte) begin
            seq_len = IDX_W'(1);
        end
    end

    assign final_piece = (idx_reg == seq_len - 1'b1);
    assign pos         = idx_reg - {{(IDX_W-1){1'b0}}, head_job.pct};
    assign pop         = take && final_piece;

    // Select the byte for this position
    always_comb begin
        if (head_job.pct && (idx_reg == '0)) begin
            piece_byte  = CH_PCT;
            piece_vbyte = 1'b1;
        end else if (head_job.has_byte) begin
            piece_byte  = ent_char(head_job.kind, head_job.data, pos);
            piece_vbyte = 1'b1;
        end else begin
            piece_byte  = 8'h00;
            piece_vbyte = 1'b0;
        end
    end

    // Advance the position within the request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (take) begin
            idx_reg <= final_piece ? '0 : idx_reg + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_byte_reg  <= piece_byte;
            m_vbyte_reg <= piece_vbyte;
            m_last_reg  <= head_job.last && final_piece;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = m_byte_reg;
    assign m_out_valid_byte = m_vbyte_reg;
    assign m_out_last       = m_last_reg;

endmodule

[design/url_unescape_html_escape_unit.sv]
// Top level of the URL percent decoder with optional HTML escaping.
// The unit takes one raw byte per cycle while the queue has room and returns
// decoded bytes; a byte that expands to an entity (&lt; &gt; &quot; &#39;) gives
// four to six output bytes, and a short '%' escape at the end of a string up to
// seven. A request is classified combinationally at the input and enters a
// QUEUE_DEPTH-entry queue; the back end drains it at one output byte per cycle
// while the receiver is ready, so the output port sets the sustained rate. The
// first output byte of a request passes the queue entry, then the output register.
// Escape bytes and bytes after a decoded zero produce nothing until the string's
// last byte, and a last byte that yields no data gives one empty end marker.
`include "assert_macros.svh"

module url_unescape_html_escape_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_valid_byte,
    output logic       m_out_last
);
    import urlhe_pkg::*;

    logic       push, pop;
    job_t       push_job, head_job;
    fifo_stat_t fifo_stat;

    // Classify incoming requests
    urlhe_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .push        (push),
        .push_job    (push_job),
        .fifo_stat   (fifo_stat)
    );

    // Decouple the two ends
    urlhe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head_job  (head_job),
        .fifo_stat (fifo_stat)
    );

    // Expand requests into output bytes
    urlhe_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_job         (head_job),
        .fifo_stat        (fifo_stat),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_out_valid_byte (m_out_valid_byte),
        .m_out_last       (m_out_last)
    );

    // Never write a full queue or read an empty one
    `URLHE_ASSERT_NEVER(a_push_full, push && fifo_stat.full)
    `URLHE_ASSERT_NEVER(a_pop_empty, pop && fifo_stat.empty)
    // An empty end marker only closes a string
    `URLHE_ASSERT(a_empty_is_last, m_valid && !m_out_valid_byte |-> m_out_last)

endmodule

[bench/url_unescape_html_escape_unit_test.sv]
// Self-checking testbench for the URL unescape unit with optional HTML escaping.
module url_unescape_html_escape_unit_test;
    import urlhe_pkg::*;

    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 10;    // settle time after the last output byte
    localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
    localparam int PHASE_ITEMS  = 100;   // least random requests per phase
    localparam int N_DIRECTED   = 25;

    // Escape decoder phase
    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2,
        ESC_SPARE = 2'd3
    } esc_phase_t;

    // One output byte as seen on the result channel
    typedef struct packed {
        logic [7:0] data;
        logic       vb;
        logic       last;
    } out_beat_t;

    // One row of the directed table
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        out_beat_t  want;
    } vector_t;

    localparam out_beat_t NO_BEAT = '0;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_in_last;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_out_valid_byte;
    logic       m_out_last;

    // Decoder copy: state, register and the results still owed
    esc_phase_t esc_phase;
    logic [7:0] held_digit;
    logic       str_ended;
    logic       html_en;
    out_beat_t  step_beats[$];
    out_beat_t  pending_beats[$];

    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_go;
    int  errors;
    int  requests_sent;
    int  strings_sent;
    int  beats_checked;
    int  quiet_cycles;
    out_beat_t want_beat;
    vector_t directed [N_DIRECTED];

    url_unescape_html_escape_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .s_in_last        (s_in_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_out_valid_byte (m_out_valid_byte),
        .m_out_last       (m_out_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Decoder copy
    // ---------------------------------------------------------------

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c >= CH_UA) begin
            return (c & HEX_CASE_MASK) - CH_UA + 8'd10;
        end
        return c - CH_0;
    endfunction

    function automatic void put_byte(input logic [7:0] c);
        step_beats.push_back('{data: c, vb: 1'b1, last: 1'b0});
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i]);
        end
    endfunction

    // Emit a decoded byte; a zero ends the string, specials become entities when escaping is on
    function automatic void emit_decoded(input logic [7:0] c);
        if (str_ended) begin
            return;
        end
        if (c == 8'h00) begin
            str_ended = 1'b1;
            return;
        end
        if (html_en && c == CH_LT) begin
            put_text("&lt;");
        end else if (html_en && c == CH_GT) begin
            put_text("&gt;");
        end else if (html_en && c == CH_QUOT) begin
            put_text("&quot;");
        end else if (html_en && c == CH_APOS) begin
            put_text("&#39;");
        end else begin
            put_byte(c);
        end
    endfunction

    function automatic void emit_plain(input logic [7:0] c);
        emit_decoded(c == CH_PLUS ? CH_SPACE : c);
    endfunction

    // Work out the output bytes of one request into step_beats
    function automatic void decode_request(input logic [7:0] c, input logic last);
        logic [7:0] hi;
        logic [7:0] lo;
        out_beat_t  tail;
        step_beats.delete();
        if (str_ended) begin
            // swallow everything after a decoded zero
        end else if (esc_phase == ESC_PCT) begin
            if (last) begin
                put_byte(CH_PCT);
                emit_plain(c);
                esc_phase = ESC_IDLE;
            end else begin
                held_digit = c;
                esc_phase = ESC_DIGIT;
            end
        end else if (esc_phase == ESC_DIGIT) begin
            hi = digit_value(held_digit);
            lo = digit_value(c);
            esc_phase = ESC_IDLE;
            emit_decoded({hi[3:0], 4'h0} + lo);
        end else if (c == CH_PCT) begin
            if (last) begin
                put_byte(CH_PCT);
            end else begin
                esc_phase = ESC_PCT;
            end
        end else begin
            emit_plain(c);
        end
        if (last) begin
            // Flag the final byte, or send an empty end marker
            if (step_beats.size() > 0) begin
                tail = step_beats.pop_back();
                tail.last = 1'b1;
                step_beats.push_back(tail);
            end else begin
                step_beats.push_back('{data: 8'h00, vb: 1'b0, last: 1'b1});
            end
            esc_phase  = ESC_IDLE;
            held_digit = 8'h00;
            str_ended  = 1'b0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Offer one request, hold it until taken, then queue what it owes
    task automatic send_request(input logic [7:0] c, input logic last, input bit typed,
                                input out_beat_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= c;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        decode_request(c, last);
        if (typed) begin
            step_beats.delete();
            step_beats.push_back(want);
        end
        foreach (step_beats[i]) begin
            pending_beats.push_back(step_beats[i]);
        end
    endtask

    // Write the escape enable once the unit has drained
    task automatic set_escape_enable(input logic en);
        s_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        html_en = en;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if ($urandom_range(9) == 0) begin
            return 8'($urandom_range(255));
        end
        if (n < 4'd10) begin
            return CH_0 + n;
        end
        return ($urandom_range(1) ? CH_UA : CH_LA) + n - 8'd10;
    endfunction

    function automatic logic [7:0] escape_target();
        case ($urandom_range(24))
            0:       return CH_LT;
            1:       return CH_GT;
            2:       return CH_QUOT;
            3:       return CH_APOS;
            4:       return CH_PLUS;
            5:       return CH_PCT;
            6:       return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        case ($urandom_range(11))
            0:       return CH_PLUS;
            1:       return CH_LT;
            2:       return CH_GT;
            3:       return CH_QUOT;
            4:       return CH_APOS;
            5:       return CH_AMP;
            default: return 8'($urandom_range(8'h7a, 8'h61));
        endcase
    endfunction

    // Build one string: mostly plain text and well-formed escapes, some noise
    task automatic send_random_string();
        logic [7:0] body[$];
        logic [7:0] v;
        int         len;
        int         pick;
        len = $urandom_range(10, 1);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                body.push_back(plain_char());
            end else if (pick < 78) begin
                v = escape_target();
                body.push_back(CH_PCT);
                body.push_back(hex_char(v[7:4]));
                body.push_back(hex_char(v[3:0]));
            end else begin
                body.push_back(8'($urandom_range(255)));
            end
        end
        // Cut an escape short at the end now and then
        pick = $urandom_range(99);
        if (pick < 8) begin
            body.push_back(CH_PCT);
        end else if (pick < 16) begin
            body.push_back(CH_PCT);
            body.push_back($urandom_range(1) ? plain_char() : CH_PCT);
        end
        foreach (body[i]) begin
            send_request(body[i], i == body.size() - 1, 1'b0, NO_BEAT);
        end
        strings_sent++;
    endtask

    // ---------------------------------------------------------------
    // Receiver, checker, watchdog
    // ---------------------------------------------------------------

    // Stall at random; hold off for a long stretch on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                hold_go = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compare each output byte with the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_checked++;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected output byte %h valid_byte %b last %b", $time,
                         m_out_byte, m_out_valid_byte, m_out_last);
                errors++;
            end else begin
                want_beat = pending_beats.pop_front();
                if (m_out_byte !== want_beat.data) begin
                    $display("%0t: out_byte expected %h actual %h", $time,
                             want_beat.data, m_out_byte);
                    errors++;
                end
                if (m_out_valid_byte !== want_beat.vb) begin
                    $display("%0t: out_valid_byte expected %b actual %b", $time,
                             want_beat.vb, m_out_valid_byte);
                    errors++;
                end
                if (m_out_last !== want_beat.last) begin
                    $display("%0t: out_last expected %b actual %b", $time,
                             want_beat.last, m_out_last);
                    errors++;
                end
            end
        end
    end

    // Give up when neither channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d bytes still owed", $time,
                         quiet_cycles, pending_beats.size());
                $display("url_unescape_html_escape_unit verification failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_valid       = 1'b0;
        s_in_byte     = 8'h00;
        s_in_last     = 1'b0;
        hold_go       = 1'b0;
        errors        = 0;
        requests_sent = 0;
        strings_sent  = 0;
        beats_checked = 0;
        quiet_cycles  = 0;
        tx_idle_pct   = 16;
        rx_idle_pct   = 82;
        esc_phase     = ESC_IDLE;
        held_digit    = 8'h00;
        str_ended     = 1'b0;
        html_en       = 1'b1;

        // Directed rows, escaping on as after reset
        directed = '{
            '{8'h00,   1'b1, 1'b1, '{8'h00,   1'b0, 1'b1}},  // zero at end: empty marker
            '{8'hff,   1'b1, 1'b1, '{8'hff,   1'b1, 1'b1}},
            '{CH_PLUS, 1'b1, 1'b1, '{CH_SPACE, 1'b1, 1'b1}},
            '{CH_PCT,  1'b1, 1'b1, '{CH_PCT,  1'b1, 1'b1}},  // lone '%' at end
            '{CH_PCT,  1'b0, 1'b0, NO_BEAT},
            '{8'h34,   1'b0, 1'b0, NO_BEAT},
            '{8'h31,   1'b1, 1'b1, '{8'h41,   1'b1, 1'b1}},  // %41 -> 'A'
            '{CH_PCT,  1'b0, 1'b0, NO_BEAT},
            '{CH_3,    1'b0, 1'b0, NO_BEAT},
            '{8'h63,   1'b0, 1'b0, NO_BEAT},                 // %3c -> entity
            '{8'h78,   1'b1, 1'b0, NO_BEAT},
            '{CH_PCT,  1'b0, 1'b0, NO_BEAT},
            '{CH_PLUS, 1'b1, 1'b0, NO_BEAT},                 // short escape, held '+'
            '{CH_PCT,  1'b0, 1'b0, NO_BEAT},
            '{CH_PCT,  1'b1, 1'b0, NO_BEAT},                 // short escape, held '%'
            '{CH_PCT,  1'b0, 1'b0, NO_BEAT},
            '{CH_0,    1'b0, 1'b0, NO_BEAT},
            '{CH_0,    1'b0, 1'b0, NO_BEAT},                 // decoded zero ends string
            '{8'h71,   1'b1, 1'b1, '{8'h00,   1'b0, 1'b1}},
            '{CH_QUOT, 1'b1, 1'b0, NO_BEAT},
            '{CH_APOS, 1'b1, 1'b0, NO_BEAT},
            '{CH_GT,   1'b1, 1'b0, NO_BEAT},
            '{CH_PCT,  1'b0, 1'b0, NO_BEAT},
            '{8'h67,   1'b0, 1'b0, NO_BEAT},                 // non-hex digits wrap
            '{8'h47,   1'b1, 1'b0, NO_BEAT}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            send_request(directed[i].data, directed[i].last, directed[i].typed,
                         directed[i].want);
        end

        // Random phases: escaping alternates off and on while the idling patterns change
        for (int ph = 0; ph < 4; ph++) begin
            int first_request;
            set_escape_enable(ph[0]);
            tx_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 82 : 0;
            rx_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 16 : 0;
            if (ph == 2) begin
                hold_go = 1'b1;
            end
            first_request = requests_sent;
            while (requests_sent - first_request < PHASE_ITEMS) begin
                send_random_string();
            end
        end

        // Drain and settle
        s_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests (%0d random strings), checked %0d output bytes,",
                 requests_sent, strings_sent, beats_checked);
        $display("with escaping on and off, both sides stalling and a long output hold-off.");
        if (errors == 0) begin
            $display("url_unescape_html_escape_unit verification clean");
        end else begin
            $display("url_unescape_html_escape_unit verification failed");
        end
        $finish;
    end

endmodule
